// File: rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg: shared definitions for the differential drive PID core
// Register indexes, reset values and default sizing of the datapath.
// ----------------------------------------------------------------------------
package pdd_pkg;

	// default datapath sizing
	localparam int DEF_GAIN_FRAC_BITS = 8;
	localparam int DEF_SUM_BITS       = 16;

	// fixed field widths
	localparam int GAIN_W  = 16;
	localparam int SPEED_W = 8;
	localparam int DIST_W  = 8;
	localparam int ERR_W   = DIST_W + 1;
	localparam int DERIV_W = ERR_W + 1;
	localparam int CFG_W   = GAIN_W;
	localparam int IDX_W   = 3;

	// register reset values
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd128;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd26;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd13;
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd150;
	localparam logic [DIST_W-1:0]  TARGET_DIST_RST = 8'd15;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

	// configuration register map
	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_BASE_SPEED  = 3'd3,
		REG_TARGET_DIST = 3'd4
	} cfg_reg_t;

endpackage

// File: rtl/pid_differential_drive_core.sv
// ----------------------------------------------------------------------------
// pid_differential_drive_core: wall-following PID steering for two motors
// Turns one side distance sample into a left and a right motor speed.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                       | direction
//  ----------+-----------------------------------------------+----------
//  sample    | sample_valid, sample_stall, measured_distance | in
//  speed     | speed_valid, speed_stall, left/right_speed    | out
//  config    | cfg_we, cfg_index, cfg_data                   | in
//
//  One transaction per clock is sustained while speed_stall is low; a result
//  is presented from the result register after its sample has passed the
//  input register. The whole PID step runs in the logic between the two
//  registers, and the integral loop closes there, so no item ever waits on
//  its predecessor. Reset loads the configuration defaults, clears the
//  integral and the last error and empties both registers. A speed stall
//  backs up only through full stages; empty stages keep taking samples.
//
module pid_differential_drive_core import pdd_pkg::*; #(
	parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
	parameter int SUM_BITS       = DEF_SUM_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// sample channel
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [DIST_W-1:0]  measured_distance,
	// speed channel
	output logic               speed_valid,
	input  logic               speed_stall,
	output logic [SPEED_W-1:0] left_speed,
	output logic [SPEED_W-1:0] right_speed
);

	// product widths: gains enter as positive signed values one bit wider
	localparam int PP_W  = GAIN_W + 1 + ERR_W;
	localparam int PI_W  = GAIN_W + 1 + SUM_BITS;
	localparam int PD_W  = GAIN_W + 1 + DERIV_W;
	localparam int ACC_W = PI_W + 2;
	localparam int ADJ_W = ACC_W - GAIN_FRAC_BITS;
	localparam int SPD_W = ADJ_W + 1;

	localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

	// configuration registers
	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [SPEED_W-1:0] base_speed_q;
	logic [DIST_W-1:0]  target_dist_q;

	// loop state
	logic signed [SUM_BITS-1:0] error_sum_q;
	logic signed [ERR_W-1:0]    last_error_q;

	// pipeline
	logic                    valid_s1, valid_s2;
	logic [DIST_W-1:0]       dist_s1;
	logic [SPEED_W-1:0]      left_s2, right_s2;

	logic load_s1, load_s2;

	// error and integral
	logic signed [ERR_W-1:0]    err_s1;
	logic signed [DERIV_W-1:0]  deriv_s1;
	logic signed [SUM_BITS:0]   sum_wide;
	logic signed [SUM_BITS-1:0] sum_next;

	// products, adjustment and clamps
	logic signed [PP_W-1:0]  prod_p;
	logic signed [PI_W-1:0]  prod_i;
	logic signed [PD_W-1:0]  prod_d;
	logic signed [ACC_W-1:0] acc;
	logic signed [ADJ_W-1:0] adj;
	logic signed [SPD_W-1:0] left_wide, right_wide;
	logic [SPEED_W-1:0]      left_clamp, right_clamp;

	// ---------------------------------------------------------------- handshake
	// A stage loads when it is empty or when its content moves on.
	assign load_s2      = !valid_s2 || !speed_stall;
	assign load_s1      = !valid_s1 || load_s2;
	assign sample_stall = !load_s1;

	// ------------------------------------------------------------ configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			base_speed_q  <= BASE_SPEED_RST;
			target_dist_q <= TARGET_DIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				REG_BASE_SPEED:  base_speed_q  <= cfg_data[SPEED_W-1:0];
				REG_TARGET_DIST: target_dist_q <= cfg_data[DIST_W-1:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// -------------------------------------------------------- stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && sample_valid) begin
			dist_s1 <= measured_distance;
		end
	end

	// Error, derivative and the saturating integral. The integral and the
	// last error commit only when the item leaves stage 1.
	always_comb begin
		err_s1   = $signed({1'b0, target_dist_q}) - $signed({1'b0, dist_s1});
		deriv_s1 = DERIV_W'(err_s1) - DERIV_W'(last_error_q);
		sum_wide = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(err_s1);
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_next = sum_wide[SUM_BITS] ? SUM_LO : SUM_HI;
		end else begin
			sum_next = sum_wide[SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (valid_s1 && load_s2) begin
			error_sum_q  <= sum_next;
			last_error_q <= err_s1;
		end
	end

	// Form the three terms, sum them, drop the fraction toward zero, steer
	// and clamp.
	always_comb begin
		prod_p = PP_W'($signed({1'b0, prop_gain_q}))  * PP_W'(err_s1);
		prod_i = PI_W'($signed({1'b0, integ_gain_q})) * PI_W'(sum_next);
		prod_d = PD_W'($signed({1'b0, deriv_gain_q})) * PD_W'(deriv_s1);
		acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
		adj = ADJ_W'(acc >>> GAIN_FRAC_BITS);
		// floor of a negative sum with a fraction left is one too low
		if (acc[ACC_W-1] && (|acc[GAIN_FRAC_BITS-1:0])) begin
			adj = adj + ADJ_W'(1);
		end
		left_wide  = $signed(SPD_W'({1'b0, base_speed_q})) + SPD_W'(adj);
		right_wide = $signed(SPD_W'({1'b0, base_speed_q})) - SPD_W'(adj);

		if (left_wide[SPD_W-1]) begin
			left_clamp = '0;
		end else if (left_wide > $signed(SPD_W'({1'b0, SPEED_MAX}))) begin
			left_clamp = SPEED_MAX;
		end else begin
			left_clamp = left_wide[SPEED_W-1:0];
		end

		if (right_wide[SPD_W-1]) begin
			right_clamp = '0;
		end else if (right_wide > $signed(SPD_W'({1'b0, SPEED_MAX}))) begin
			right_clamp = SPEED_MAX;
		end else begin
			right_clamp = right_wide[SPEED_W-1:0];
		end
	end

	// ---------------------------------------------------------- stage 2: result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			left_s2  <= left_clamp;
			right_s2 <= right_clamp;
		end
	end

	assign speed_valid = valid_s2;
	assign left_speed  = left_s2;
	assign right_speed = right_s2;

	// ---------------------------------------------------------------- checks
	// An empty result register never holds off a sample.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !sample_stall)
		else $error("sample stalled with an empty result register");

	// The integral moves only when an item leaves stage 1.
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && load_s2) |=> $stable(error_sum_q))
		else $error("integral changed without an item");

	// The last error tracks the item that just left stage 1.
	a_last_error: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=> last_error_q == $past(err_s1))
		else $error("last error not updated from the departing item");

	// A new result only comes from a full input stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without an input stage item");

endmodule
